// File: hdl/pds_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared constants, sequencer states and control structs.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int CLK_W         = 20;
  localparam int CODE_W        = 10;
  localparam int PCODE_W       = 7;
  localparam int P_W           = 3;
  localparam int Q_W           = 4;
  localparam int R_W           = 18;
  localparam int ERR_W         = 19;

  localparam int VCO_MAX_KHZ   = 600000;
  localparam int REF_KHZ       = 96000;
  localparam int HALF_REF_KHZ  = 48000;
  localparam int P_MAX         = 5;
  localparam int TOL_MAX_PER_M = 480;
  localparam int TOL_TGT_PER_M = 96;
  localparam int M_MIN         = 3;
  localparam int M_MIN_Y       = 288000;
  localparam int N_START       = 3;
  localparam int CODE_OFFSET   = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSEL,
    ST_DIV,
    ST_STEP,
    ST_CORR,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic psel;
    logic div;
    logic step;
    logic corr;
    logic eval;
  } dp_cmd_t;

  typedef struct packed {
    logic psel_more;
    logic div_more;
    logic n_small;
    logic stop;
  } dp_status_t;

endpackage

// File: hdl/pds_ctrl.sv
// ----------------------------------------------------------------------------
// PLL divider search sequencer
// Steps the shared datapath through post divider selection, quotient
// setup and the reference divider walk, and runs both handshakes.
// ----------------------------------------------------------------------------
module pds_ctrl
  import pds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PSEL;
      end
      ST_PSEL: begin
        if (!status.psel_more) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_more) state_next = ST_STEP;
      end
      ST_STEP: state_next = ST_CORR;
      ST_CORR: begin
        state_next = status.n_small ? ST_STEP : ST_EVAL;
      end
      ST_EVAL: begin
        state_next = status.stop ? ST_DONE : ST_STEP;
      end
      ST_DONE: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.psel  = (state == ST_PSEL);
    cmd.div   = (state == ST_DIV);
    cmd.step  = (state == ST_STEP);
    cmd.corr  = (state == ST_CORR);
    cmd.eval  = (state == ST_EVAL);
  end

endmodule

// File: hdl/pds_datapath.sv
// ----------------------------------------------------------------------------
// PLL divider search datapath
// Holds the running products and remainders of the N walk and the shared
// add, compare and subtract logic that the sequencer applies step by step.
// ----------------------------------------------------------------------------
module pds_datapath
  import pds_pkg::*;
#(
  parameter int SOFT_N_LIMIT = 30,
  parameter int HARD_N_LIMIT = 1025
) (
  input  logic                 clk,
  input  logic [CLK_W-1:0]     pixel_clock_khz,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [CODE_W-1:0]    m_code,
  output logic [CODE_W-1:0]    n_code,
  output logic [PCODE_W-1:0]   p_code,
  output logic                 found
);

  localparam int N_MAX = (SOFT_N_LIMIT > HARD_N_LIMIT) ? SOFT_N_LIMIT : HARD_N_LIMIT;
  localparam int NW    = $clog2(N_MAX + 1);
  localparam int XW    = CLK_W + NW;
  localparam int MW    = XW - 15;
  localparam int CW    = MW + 10;

  logic [P_W-1:0]    p;
  logic [CLK_W-1:0]  vco;
  logic [Q_W-1:0]    q;
  logic [CLK_W-1:0]  rem;
  logic [R_W-1:0]    r;
  logic [XW-1:0]     x;
  logic [MW-1:0]     m;
  logic [NW-1:0]     n;
  logic [CODE_W-1:0] m_best;
  logic [CODE_W-1:0] n_best;

  logic              clamp;
  logic [MW-1:0]     mc;
  logic [ERR_W-1:0]  err;
  logic [CW-1:0]     tol_max;
  logic [CW-1:0]     tol_tgt;
  logic              within_max;
  logic              within_tgt;

  always_comb begin
    clamp = (m < MW'(M_MIN));
    mc    = clamp ? MW'(M_MIN) : m;
    if (clamp) begin
      err = ERR_W'(M_MIN_Y) - x[ERR_W-1:0];
    end else if (r >= R_W'(HALF_REF_KHZ)) begin
      err = ERR_W'(r - R_W'(HALF_REF_KHZ));
    end else begin
      err = ERR_W'(R_W'(HALF_REF_KHZ) - r);
    end
    tol_max    = CW'(mc) * CW'(TOL_MAX_PER_M);
    tol_tgt    = CW'(mc) * CW'(TOL_TGT_PER_M);
    within_max = (CW'(err) < tol_max);
    within_tgt = (CW'(err) < tol_tgt);

    status.psel_more = (p < P_W'(P_MAX)) &&
                       ({vco, 1'b0} <= (CLK_W + 1)'(VCO_MAX_KHZ));
    status.div_more  = (rem >= CLK_W'(REF_KHZ));
    status.n_small   = (n < NW'(N_START));
    status.stop      = within_tgt ||
                       ((found || within_max) && (n > NW'(SOFT_N_LIMIT))) ||
                       (n >= NW'(HARD_N_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p      <= '0;
      vco    <= pixel_clock_khz;
      x      <= '0;
      r      <= R_W'(HALF_REF_KHZ);
      m      <= '0;
      n      <= '0;
      found  <= 1'b0;
      m_best <= '0;
      n_best <= '0;
    end
    if (cmd.psel) begin
      if (status.psel_more) begin
        p   <= p + P_W'(1);
        vco <= {vco[CLK_W-2:0], 1'b0};
      end else begin
        rem <= vco;
        q   <= '0;
      end
    end
    if (cmd.div && status.div_more) begin
      rem <= rem - CLK_W'(REF_KHZ);
      q   <= q + Q_W'(1);
    end
    if (cmd.step) begin
      x <= x + XW'(vco);
      r <= r + R_W'(rem);
      m <= m + MW'(q);
      n <= n + NW'(1);
    end
    if (cmd.corr && (r >= R_W'(REF_KHZ))) begin
      r <= r - R_W'(REF_KHZ);
      m <= m + MW'(1);
    end
    if (cmd.eval && within_max) begin
      found  <= 1'b1;
      m_best <= CODE_W'(mc - MW'(CODE_OFFSET));
      n_best <= CODE_W'(n - NW'(CODE_OFFSET));
    end
  end

  assign m_code = m_best;
  assign n_code = n_best;
  assign p_code = {p, 4'b0000};

endmodule

// File: hdl/pll_divider_search.sv
// ----------------------------------------------------------------------------
// PLL divider search
// Finds M, N and P divider codes for a requested pixel clock.
//
//   Channel  Signals                                  Direction
//   input    in_valid, in_ready, pixel_clock_khz      into the block
//   output   out_valid, out_ready, m_code, n_code,    out of the block
//            p_code, found
//
// One transaction runs post divider selection, then quotient setup, then the
// N walk: each N below 3 takes a step and a correction, and each N evaluated
// takes a step, a correction and an evaluation. The N walk in the shared add,
// compare and subtract datapath sets the length of a transaction.
// The block takes one transaction at a time and holds its result until it is
// taken. Reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module pll_divider_search
  import pds_pkg::*;
#(
  parameter int SOFT_N_LIMIT = 30,
  parameter int HARD_N_LIMIT = 1025
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CLK_W-1:0]   pixel_clock_khz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CODE_W-1:0]  m_code,
  output logic [CODE_W-1:0]  n_code,
  output logic [PCODE_W-1:0] p_code,
  output logic               found
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pds_datapath #(
    .SOFT_N_LIMIT (SOFT_N_LIMIT),
    .HARD_N_LIMIT (HARD_N_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .pixel_clock_khz (pixel_clock_khz),
    .cmd             (cmd),
    .status          (status),
    .m_code          (m_code),
    .n_code          (n_code),
    .p_code          (p_code),
    .found           (found)
  );

endmodule

// File: dv/tb_pll_divider_search.sv
// ----------------------------------------------------------------------------
// PLL divider search testbench
// Sends requested pixel clocks through the valid/ready input channel and
// checks every returned M, N and P code set against an in-bench divider
// search. Corner clocks come first: zero, tiny clocks that cannot lock,
// post divider boundaries and values above 600 MHz. About 1700 random
// clocks follow, with random gaps on both channels and one calm stretch.
// ----------------------------------------------------------------------------
module tb_pll_divider_search
  import pds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SOFT_N          = 30;
  localparam int HARD_N          = 1025;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int CALM_FIRST      = 700;
  localparam int CALM_LAST       = 1000;
  localparam int DRAIN_CYCLES    = 3 * HARD_N + 100;
  localparam int LIMIT_CYCLES    = 25_000_000;

  localparam int unsigned CORNER_KHZ [23] = '{
    0, 1, 2, 3, 40, 18750, 18751, 37500, 37501, 75000, 75001, 150000,
    150001, 300000, 300001, 599999, 600000, 600001, 1048575, 25175, 65000,
    699050, 349525
  };

  typedef struct packed {
    logic [CODE_W-1:0]  m_code;
    logic [CODE_W-1:0]  n_code;
    logic [PCODE_W-1:0] p_code;
    logic               found;
  } pll_codes_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CLK_W-1:0]   pixel_clock_khz = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CODE_W-1:0]  m_code;
  logic [CODE_W-1:0]  n_code;
  logic [PCODE_W-1:0] p_code;
  logic               found;

  logic               in_fire = 1'b0;
  logic [CLK_W-1:0]   clock_requests [$];
  pll_codes_t         codes_due [$];
  int unsigned        requests_sent = 0;
  int unsigned        codes_seen = 0;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;

  pll_divider_search #(
    .SOFT_N_LIMIT(SOFT_N),
    .HARD_N_LIMIT(HARD_N)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_clock_khz(pixel_clock_khz),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .m_code         (m_code),
    .n_code         (n_code),
    .p_code         (p_code),
    .found          (found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Picks the post divider, then walks N upward and keeps the last M, N pair
  // within half a percent until a pair within a tenth of a percent turns up or an N limit is reached.
  function automatic pll_codes_t search_dividers(logic [CLK_W-1:0] khz);
    longint unsigned wide;
    longint unsigned vco;
    longint unsigned x;
    longint unsigned m;
    longint unsigned y;
    longint unsigned err;
    longint unsigned m_keep;
    longint unsigned n_keep;
    int unsigned     p;
    int unsigned     n;
    bit              hit;
    bit              stop;
    pll_codes_t      codes;
    wide = khz;
    p = 0;
    while (p < P_MAX && (wide << (p + 1)) <= VCO_MAX_KHZ) p++;
    vco = wide << p;
    hit = 1'b0;
    stop = 1'b0;
    m_keep = 0;
    n_keep = 0;
    n = N_START;
    while (!stop) begin
      x = vco * n;
      m = (x + HALF_REF_KHZ) / REF_KHZ;
      if (m < M_MIN) m = M_MIN;
      y = REF_KHZ * m;
      err = (y >= x) ? (y - x) : (x - y);
      if (err < TOL_MAX_PER_M * m) begin
        hit = 1'b1;
        m_keep = m;
        n_keep = n;
      end
      if (err < TOL_TGT_PER_M * m) stop = 1'b1;
      else if (hit && n > SOFT_N) stop = 1'b1;
      else if (n >= HARD_N) stop = 1'b1;
      else n++;
    end
    codes.m_code = hit ? CODE_W'(m_keep - CODE_OFFSET) : '0;
    codes.n_code = hit ? CODE_W'(n_keep - CODE_OFFSET) : '0;
    codes.p_code = PCODE_W'(p << 4);
    codes.found  = hit;
    return codes;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && !in_fire) begin
        in_valid <= 1'b1;
      end else if (clock_requests.size() != 0 &&
                   ((requests_sent >= CALM_FIRST && requests_sent < CALM_LAST) ||
                    $urandom_range(0, 99) >= 20)) begin
        pixel_clock_khz <= clock_requests.pop_front();
        in_valid        <= 1'b1;
        requests_sent++;
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= (codes_seen >= CALM_FIRST && codes_seen < CALM_LAST) ||
                   ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    pll_codes_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) codes_due.push_back(search_dividers(pixel_clock_khz));
      if (out_valid && out_ready) begin
        codes_seen++;
        if (codes_due.size() == 0) begin
          $error("result transaction with no request pending: m_code %0d n_code %0d",
                 m_code, n_code);
          error_count++;
        end else begin
          want = codes_due.pop_front();
          if (m_code !== want.m_code) begin
            $error("m_code: expected %0d, actual %0d", want.m_code, m_code);
            error_count++;
          end
          if (n_code !== want.n_code) begin
            $error("n_code: expected %0d, actual %0d", want.n_code, n_code);
            error_count++;
          end
          if (p_code !== want.p_code) begin
            $error("p_code: expected %0d, actual %0d", want.p_code, p_code);
            error_count++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_pll_divider_search: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned      pick;
    logic [CLK_W-1:0] khz;
    foreach (CORNER_KHZ[i]) clock_requests.push_back(CLK_W'(CORNER_KHZ[i]));
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) khz = CLK_W'($urandom_range(0, 40));
      else if (pick < 8) khz = CLK_W'($urandom_range(41, 4000));
      else if (pick < 22) khz = CLK_W'($urandom_range(600001, 1048575));
      else khz = CLK_W'($urandom_range(1, 600000));
      clock_requests.push_back(khz);
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (clock_requests.size() != 0 || in_valid || codes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && codes_due.size() == 0) begin
      $display("tb_pll_divider_search: done, clean");
    end else begin
      $display("tb_pll_divider_search: done, errors");
    end
    $finish;
  end

endmodule
